FILE: hdl/assert_macros.svh
// Assertion macros for the RTL of the biquad cascade.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BQC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BQC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/bqc_pkg.sv
// Shared types and constants for the biquad plus first-order cascade.
// No dependencies; used by the MAC unit and the top level.
package bqc_pkg;

  localparam int MAX_CHANNELS_DEF = 8;
  localparam int SAMPLE_WIDTH_DEF = 24;

  localparam int CHAN_W    = 3;
  localparam int COEF_W    = 32;
  localparam int COEF_FRAC = 28;
  localparam int ACC_W     = 64;
  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = 3;

  // Coefficient register indexes; a MAC step uses the coefficient of the same index.
  typedef enum logic [REG_IDX_W-1:0] {
    REG_BQ_B0 = 3'd0,
    REG_BQ_B1 = 3'd1,
    REG_BQ_B2 = 3'd2,
    REG_BQ_A1 = 3'd3,
    REG_BQ_A2 = 3'd4,
    REG_FO_B0 = 3'd5,
    REG_FO_B1 = 3'd6,
    REG_FO_A1 = 3'd7
  } reg_idx_e;

  localparam logic [COEF_W-1:0] COEF_ONE  = 32'h1000_0000;
  localparam logic [COEF_W-1:0] COEF_ZERO = 32'h0000_0000;

  typedef struct packed {
    logic mul_en;   // multiply the current operands into the product register
    logic sub;      // the product is subtracted from the accumulator
    logic acc_clr;  // start a new sum
  } mac_ctrl_t;

endpackage

FILE: hdl/bqc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module bqc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/bqc_mac.sv
// Shared multiply-accumulate unit with round-half-up and saturation.
// Depends on bqc_pkg for widths and the control struct.
module bqc_mac #(
  parameter int SAMPLE_WIDTH = bqc_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  bqc_pkg::mac_ctrl_t                 ctrl_i,
  input  logic signed [bqc_pkg::COEF_W-1:0]  coef_i,
  input  logic signed [SAMPLE_WIDTH-1:0]     data_i,
  output logic signed [SAMPLE_WIDTH-1:0]     res_o
);

  localparam int PROD_W = bqc_pkg::COEF_W + SAMPLE_WIDTH;
  localparam int RND_W  = bqc_pkg::ACC_W - bqc_pkg::COEF_FRAC;

  logic signed [PROD_W-1:0]          prod_q;
  logic                              pv_q;
  logic                              sub_q;
  logic signed [bqc_pkg::ACC_W-1:0]  acc_q;
  logic signed [bqc_pkg::ACC_W-1:0]  acc_d;
  logic signed [bqc_pkg::ACC_W-1:0]  prod_ext;
  logic signed [bqc_pkg::ACC_W-1:0]  rnd_sum;
  logic signed [RND_W-1:0]           rnd_val;
  logic                              in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q  <= 1'b0;
      sub_q <= 1'b0;
    end else begin
      pv_q  <= ctrl_i.mul_en;
      sub_q <= ctrl_i.sub;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= coef_i * data_i;
    end
    acc_q <= acc_d;
  end

  assign prod_ext = bqc_pkg::ACC_W'(prod_q);

  // The sum wraps at the accumulator width.
  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.acc_clr) begin
      acc_d = '0;
    end else if (pv_q) begin
      acc_d = sub_q ? (acc_q - prod_ext) : (acc_q + prod_ext);
    end
  end

  assign rnd_sum  = acc_q + (bqc_pkg::ACC_W'(1) <<< (bqc_pkg::COEF_FRAC - 1));
  assign rnd_val  = rnd_sum[bqc_pkg::ACC_W-1:bqc_pkg::COEF_FRAC];
  assign in_range = (rnd_val[RND_W-1:SAMPLE_WIDTH-1] == '0) ||
                    (rnd_val[RND_W-1:SAMPLE_WIDTH-1] == '1);

  always_comb begin
    if (in_range) begin
      res_o = rnd_val[SAMPLE_WIDTH-1:0];
    end else if (rnd_val[RND_W-1]) begin
      res_o = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end else begin
      res_o = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end
  end

endmodule

FILE: hdl/biquad_first_order_iir_cascade.sv
// Top level: per-channel biquad followed by a first-order IIR section.
// Depends on bqc_pkg, bqc_ram, bqc_mac and assert_macros.svh.
//
//   channel  handshake                  payload
//   in       in_valid_i / in_ready_o    chan_i, sample_in_i
//   out      out_valid_o / out_ready_i  chan_out_o, sample_out_o
//   cfg      cfg_we_i (no wait)         cfg_idx_i, cfg_data_i
//
// Items are taken one at a time: a result is registered as its item leaves the last step,
// and the next input beat is taken in idle. The pace is set by the single multiplier:
// eight products one per cycle, a registered product ahead of the adder, two rounding steps.
// The channel state sits in one RAM word per channel; per-channel valid bits, cleared by
// reset, make an unwritten word read as zero, so no clearing pass is needed.
// A stalled output holds the item in its last step; the state write-back waits with it.
`include "assert_macros.svh"

module biquad_first_order_iir_cascade #(
  parameter int MAX_CHANNELS = bqc_pkg::MAX_CHANNELS_DEF,
  parameter int SAMPLE_WIDTH = bqc_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [bqc_pkg::CHAN_W-1:0]           chan_i,
  input  logic signed [SAMPLE_WIDTH-1:0]       sample_in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [bqc_pkg::CHAN_W-1:0]           chan_out_o,
  output logic signed [SAMPLE_WIDTH-1:0]       sample_out_o,
  input  logic                                 cfg_we_i,
  input  logic [bqc_pkg::REG_IDX_W-1:0]        cfg_idx_i,
  input  logic [bqc_pkg::COEF_W-1:0]           cfg_data_i
);

  localparam int AW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int ROW_W  = 6 * SAMPLE_WIDTH;
  localparam int MOD_W  = 7;

  // Word layout, one field per delay store.
  localparam int F_BQ_IN1  = 0;
  localparam int F_BQ_IN2  = 1;
  localparam int F_BQ_OUT1 = 2;
  localparam int F_BQ_OUT2 = 3;
  localparam int F_FO_IN1  = 4;
  localparam int F_FO_OUT1 = 5;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_BQ_MAC  = 7'b0000010,
    S_BQ_LAST = 7'b0000100,
    S_BQ_RND  = 7'b0001000,
    S_FO_MAC  = 7'b0010000,
    S_FO_LAST = 7'b0100000,
    S_FO_RND  = 7'b1000000
  } state_e;

  state_e                            state_q, state_d;
  bqc_pkg::reg_idx_e                 step_q, step_d;
  logic [bqc_pkg::COEF_W-1:0]        coef_q [bqc_pkg::NUM_REGS];
  logic [MAX_CHANNELS-1:0]           valid_q;
  logic                              rowv_q;
  logic [AW-1:0]                     idx_q;
  logic [AW-1:0]                     chan_idx;
  logic [bqc_pkg::CHAN_W-1:0]        chan_q;
  logic signed [SAMPLE_WIDTH-1:0]    x_q;
  logic signed [SAMPLE_WIDTH-1:0]    y_q;
  logic                              out_valid_q;
  logic [bqc_pkg::CHAN_W-1:0]        out_chan_q;
  logic signed [SAMPLE_WIDTH-1:0]    out_sample_q;

  logic                              in_fire;
  logic                              out_load;
  logic [ROW_W-1:0]                  rd_row;
  logic [ROW_W-1:0]                  row;
  logic [ROW_W-1:0]                  wr_row;
  logic signed [SAMPLE_WIDTH-1:0]    mac_data;
  logic                              mac_sub;
  logic signed [SAMPLE_WIDTH-1:0]    mac_res;
  bqc_pkg::mac_ctrl_t                mac_ctrl;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_FO_RND) && (!out_valid_q || out_ready_i);

  // Channel numbers past the store depth wrap around it.
  always_comb begin
    logic [MOD_W-1:0] m;
    m = MOD_W'(chan_i);
    for (int i = 0; i < 8; i++) begin
      if (m >= MOD_W'(MAX_CHANNELS)) begin
        m = m - MOD_W'(MAX_CHANNELS);
      end
    end
    chan_idx = m[AW-1:0];
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bqc_pkg::NUM_REGS; i++) begin
        coef_q[i] <= bqc_pkg::COEF_ZERO;
      end
      coef_q[bqc_pkg::REG_BQ_B0] <= bqc_pkg::COEF_ONE;
      coef_q[bqc_pkg::REG_FO_B0] <= bqc_pkg::COEF_ONE;
    end else if (cfg_we_i) begin
      coef_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  bqc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_CHANNELS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (out_load),
    .waddr_i (idx_q),
    .wdata_i (wr_row),
    .re_i    (in_fire),
    .raddr_i (chan_idx),
    .rdata_o (rd_row)
  );

  assign row = rowv_q ? rd_row : '0;

  assign wr_row = {mac_res,
                   y_q,
                   row[F_BQ_OUT1*SAMPLE_WIDTH +: SAMPLE_WIDTH],
                   y_q,
                   row[F_BQ_IN1*SAMPLE_WIDTH +: SAMPLE_WIDTH],
                   x_q};

  // Operand selection: step k multiplies coefficient k by its delay-line tap.
  always_comb begin
    mac_sub = 1'b0;
    unique case (step_q)
      bqc_pkg::REG_BQ_B0: mac_data = x_q;
      bqc_pkg::REG_BQ_B1: mac_data = row[F_BQ_IN1*SAMPLE_WIDTH +: SAMPLE_WIDTH];
      bqc_pkg::REG_BQ_B2: mac_data = row[F_BQ_IN2*SAMPLE_WIDTH +: SAMPLE_WIDTH];
      bqc_pkg::REG_BQ_A1: begin
        mac_data = row[F_BQ_OUT1*SAMPLE_WIDTH +: SAMPLE_WIDTH];
        mac_sub  = 1'b1;
      end
      bqc_pkg::REG_BQ_A2: begin
        mac_data = row[F_BQ_OUT2*SAMPLE_WIDTH +: SAMPLE_WIDTH];
        mac_sub  = 1'b1;
      end
      bqc_pkg::REG_FO_B0: mac_data = y_q;
      bqc_pkg::REG_FO_B1: mac_data = row[F_FO_IN1*SAMPLE_WIDTH +: SAMPLE_WIDTH];
      bqc_pkg::REG_FO_A1: begin
        mac_data = row[F_FO_OUT1*SAMPLE_WIDTH +: SAMPLE_WIDTH];
        mac_sub  = 1'b1;
      end
    endcase
  end

  assign mac_ctrl.mul_en  = (state_q == S_BQ_MAC) || (state_q == S_FO_MAC);
  assign mac_ctrl.sub     = mac_sub;
  assign mac_ctrl.acc_clr = in_fire || (state_q == S_BQ_RND);

  bqc_mac #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .coef_i (coef_q[step_q]),
    .data_i (mac_data),
    .res_o  (mac_res)
  );

  // Sequencer.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_BQ_MAC;
          step_d  = bqc_pkg::REG_BQ_B0;
        end
      end
      S_BQ_MAC: begin
        step_d = bqc_pkg::reg_idx_e'(step_q + 3'd1);
        if (step_q == bqc_pkg::REG_BQ_A2) begin
          state_d = S_BQ_LAST;
        end
      end
      S_BQ_LAST: state_d = S_BQ_RND;
      S_BQ_RND:  state_d = S_FO_MAC;
      S_FO_MAC: begin
        step_d = bqc_pkg::reg_idx_e'(step_q + 3'd1);
        if (step_q == bqc_pkg::REG_FO_A1) begin
          state_d = S_FO_LAST;
        end
      end
      S_FO_LAST: state_d = S_FO_RND;
      S_FO_RND: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= bqc_pkg::REG_BQ_B0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (out_load) begin
        valid_q[idx_q] <= 1'b1;
        out_valid_q    <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      chan_q <= chan_i;
      x_q    <= sample_in_i;
      idx_q  <= chan_idx;
      rowv_q <= valid_q[chan_idx];
    end
    if (state_q == S_BQ_RND) begin
      y_q <= mac_res;
    end
    if (out_load) begin
      out_chan_q   <= chan_q;
      out_sample_q <= mac_res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign chan_out_o   = out_chan_q;
  assign sample_out_o = out_sample_q;

  `BQC_ASSERT_NEXT(a_beat_starts, in_fire, state_q == S_BQ_MAC, "beat did not start the biquad")
  `BQC_ASSERT_IMPL(a_result_src, $rose(out_valid_q), $past(state_q) == S_FO_RND, "early result")
  `BQC_ASSERT_NEXT(a_result_tag, out_load, chan_out_o == $past(chan_q), "result lost its tag")

endmodule

FILE: bench/bqc_cascade_checker.sv
// Scoreboard for the biquad plus first-order cascade: watches the input, output and
// coefficient ports, predicts each filtered sample and compares it with the block's result.
// Depends on bqc_pkg for widths and register indexes.
module bqc_cascade_checker
  import bqc_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [CHAN_W-1:0]              chan_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [CHAN_W-1:0]              chan_out_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_out_i,
  input  logic                           cfg_we_i,
  input  logic [REG_IDX_W-1:0]           cfg_idx_i,
  input  logic [COEF_W-1:0]              cfg_data_i,
  output int                             err_cnt_o,
  output int                             pending_o
);

  typedef struct packed {
    logic [CHAN_W-1:0]              chan;
    logic signed [SAMPLE_WIDTH-1:0] sample;
  } filtered_t;

  filtered_t filtered_q[$];
  int        errors;

  logic [COEF_W-1:0]              coef_r [NUM_REGS];
  logic signed [SAMPLE_WIDTH-1:0] bq_x1 [MAX_CHANNELS_DEF];
  logic signed [SAMPLE_WIDTH-1:0] bq_x2 [MAX_CHANNELS_DEF];
  logic signed [SAMPLE_WIDTH-1:0] bq_y1 [MAX_CHANNELS_DEF];
  logic signed [SAMPLE_WIDTH-1:0] bq_y2 [MAX_CHANNELS_DEF];
  logic signed [SAMPLE_WIDTH-1:0] fo_u1 [MAX_CHANNELS_DEF];
  logic signed [SAMPLE_WIDTH-1:0] fo_z1 [MAX_CHANNELS_DEF];

  function automatic longint coef_val(reg_idx_e idx);
    return longint'($signed(coef_r[idx]));
  endfunction

  // Round half up, drop the coefficient fraction bits, then clamp to the sample range.
  function automatic logic signed [SAMPLE_WIDTH-1:0] round_clamp(longint acc);
    longint hi;
    longint lo;
    longint r;
    hi = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
    lo = -hi - 1;
    r  = (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
    if (r > hi) begin
      r = hi;
    end else if (r < lo) begin
      r = lo;
    end
    return r[SAMPLE_WIDTH-1:0];
  endfunction

  // Runs one sample through both sections and advances that channel's delay line.
  function automatic logic signed [SAMPLE_WIDTH-1:0] cascade_filter(
    logic [CHAN_W-1:0] ch, logic signed [SAMPLE_WIDTH-1:0] x);
    int unsigned                    c;
    longint                         acc;
    logic signed [SAMPLE_WIDTH-1:0] y;
    logic signed [SAMPLE_WIDTH-1:0] z;
    c   = ch % MAX_CHANNELS_DEF;
    acc = coef_val(REG_BQ_B0) * x + coef_val(REG_BQ_B1) * bq_x1[c]
        + coef_val(REG_BQ_B2) * bq_x2[c] - coef_val(REG_BQ_A1) * bq_y1[c]
        - coef_val(REG_BQ_A2) * bq_y2[c];
    y = round_clamp(acc);
    bq_x2[c] = bq_x1[c];
    bq_x1[c] = x;
    bq_y2[c] = bq_y1[c];
    bq_y1[c] = y;
    acc = coef_val(REG_FO_B0) * y + coef_val(REG_FO_B1) * fo_u1[c]
        - coef_val(REG_FO_A1) * fo_z1[c];
    z = round_clamp(acc);
    fo_u1[c] = y;
    fo_z1[c] = z;
    return z;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    filtered_t want;
    if (!rst_ni) begin
      foreach (coef_r[i]) coef_r[i] = COEF_ZERO;
      coef_r[REG_BQ_B0] = COEF_ONE;
      coef_r[REG_FO_B0] = COEF_ONE;
      for (int c = 0; c < MAX_CHANNELS_DEF; c++) begin
        bq_x1[c] = '0;
        bq_x2[c] = '0;
        bq_y1[c] = '0;
        bq_y2[c] = '0;
        fo_u1[c] = '0;
        fo_z1[c] = '0;
      end
      filtered_q.delete();
      errors = 0;
      err_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i && cfg_idx_i < NUM_REGS) begin
        coef_r[cfg_idx_i] = cfg_data_i;
      end
      // Retire the output beat first, so a result can never match an input of the same edge.
      if (out_valid_i && out_ready_i) begin
        if (filtered_q.size() == 0) begin
          if (errors < 10) begin
            $display("unexpected output beat: chan %0d sample %0d", chan_out_i, sample_out_i);
          end
          errors++;
        end else begin
          want = filtered_q.pop_front();
          if (want.chan !== chan_out_i || want.sample !== sample_out_i) begin
            if (errors < 10) begin
              $display("mismatch: chan exp %0d got %0d, sample exp %0d got %0d",
                       want.chan, chan_out_i, want.sample, sample_out_i);
            end
            errors++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        filtered_q.push_back('{chan: chan_i, sample: cascade_filter(chan_i, sample_in_i)});
      end
      err_cnt_o <= errors;
      pending_o <= filtered_q.size();
    end
  end

endmodule

FILE: bench/biquad_first_order_iir_cascade_tb.sv
// Testbench top for the biquad plus first-order cascade: clock, reset, coefficient
// phases and sample stimulus with random idling, and the final verdict.
// Depends on bqc_pkg, the cascade RTL and bqc_cascade_checker.
module biquad_first_order_iir_cascade_tb;
  import bqc_pkg::*;

  localparam int SW          = SAMPLE_WIDTH_DEF;
  localparam int SETTLE      = 16;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 64;

  localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

  localparam logic [COEF_W-1:0] COEF_MAX  = 32'h7FFF_FFFF;
  localparam logic [COEF_W-1:0] COEF_MIN  = 32'h8000_0000;
  localparam logic [COEF_W-1:0] COEF_HALF = 32'h0800_0000;

  logic                 clk_i      = 1'b0;
  logic                 rst_ni     = 1'b0;
  logic                 in_valid   = 1'b0;
  logic                 in_ready;
  logic [CHAN_W-1:0]    chan       = '0;
  logic signed [SW-1:0] sample     = '0;
  logic                 out_valid;
  logic                 out_ready  = 1'b0;
  logic [CHAN_W-1:0]    chan_out;
  logic signed [SW-1:0] sample_out;
  logic                 cfg_we     = 1'b0;
  logic [REG_IDX_W-1:0] cfg_idx    = '0;
  logic [COEF_W-1:0]    cfg_data   = '0;

  bit steady    = 1'b0;
  int err_cnt;
  int pending;
  int sent      = 0;
  int coef_sets = 1;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  biquad_first_order_iir_cascade i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .chan_i       (chan),
    .sample_in_i  (sample),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .chan_out_o   (chan_out),
    .sample_out_o (sample_out),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data)
  );

  bqc_cascade_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .chan_i       (chan),
    .sample_in_i  (sample),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .chan_out_i   (chan_out),
    .sample_out_i (sample_out),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .err_cnt_o    (err_cnt),
    .pending_o    (pending)
  );

  // The receiver stalls at random, except during the steady stretch.
  always @(posedge clk_i) begin
    out_ready <= steady || ($urandom_range(99) >= 18);
  end

  // Offers one sample beat after a random gap and returns at the edge that accepts it.
  task automatic push_sample(input logic [CHAN_W-1:0] ch, input logic signed [SW-1:0] x);
    while (!steady && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    chan     <= ch;
    sample   <= x;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sent++;
  endtask

  task automatic load_coefs(input logic [COEF_W-1:0] vals [NUM_REGS]);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= reg_idx_e'(i);
      cfg_data <= vals[i];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
    coef_sets++;
  endtask

  // Stops offering beats and waits until every filtered sample is back and the block is idle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic logic [COEF_W-1:0] pick_coef(int kind);
    case (kind)
      0: return $urandom_range(2 * COEF_HALF - 1) - COEF_HALF;
      1: return $urandom();
      default: begin
        case ($urandom_range(3))
          0: return COEF_MAX;
          1: return COEF_MIN;
          2: return COEF_ZERO;
          default: return COEF_ONE;
        endcase
      end
    endcase
  endfunction

  function automatic logic signed [SW-1:0] pick_sample();
    case ($urandom_range(9))
      6: return SMAX;
      7: return SMIN;
      8: return SW'($urandom_range(510) - 255);
      9: return SW'($urandom_range(2) - 1);
      default: return SW'($urandom());
    endcase
  endfunction

  initial begin
    logic [COEF_W-1:0] coefs [NUM_REGS];
    logic [CHAN_W-1:0] ch;
    ch = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset coefficients pass samples through; hit the sample extremes on every channel.
    push_sample(3'd0, SMAX);
    push_sample(3'd1, SMIN);
    push_sample(3'd2, '0);
    push_sample(3'd3, 24'sd1);
    push_sample(3'd4, -24'sd1);
    push_sample(3'd5, 24'h555555);
    push_sample(3'd6, 24'hAAAAAA);
    push_sample(3'd7, SMAX);
    drain();

    // A gain of one half puts results exactly on the rounding midpoint.
    foreach (coefs[i]) coefs[i] = COEF_ZERO;
    coefs[REG_BQ_B0] = COEF_HALF;
    coefs[REG_FO_B0] = COEF_ONE;
    load_coefs(coefs);
    push_sample(3'd0, 24'sd1);
    push_sample(3'd0, -24'sd1);
    push_sample(3'd1, 24'sd3);
    push_sample(3'd1, -24'sd3);
    drain();

    // Extreme coefficients drive both sections into saturation in both directions.
    coefs[REG_BQ_B0] = COEF_MAX;
    coefs[REG_BQ_B1] = COEF_MIN;
    coefs[REG_BQ_B2] = COEF_MAX;
    coefs[REG_BQ_A1] = COEF_MIN;
    coefs[REG_BQ_A2] = COEF_MAX;
    coefs[REG_FO_B0] = COEF_MIN;
    coefs[REG_FO_B1] = COEF_MAX;
    coefs[REG_FO_A1] = COEF_MIN;
    load_coefs(coefs);
    push_sample(3'd2, SMAX);
    push_sample(3'd2, SMIN);
    push_sample(3'd2, SMAX);
    push_sample(3'd3, -24'sd1);
    push_sample(3'd3, 24'sd1);
    push_sample(3'd5, SMIN);
    drain();

    // Random phases: gentle, full-range and extreme coefficient sets in turn.
    for (int p = 0; p < RAND_PHASES; p++) begin
      foreach (coefs[i]) coefs[i] = pick_coef(p % 3);
      load_coefs(coefs);
      steady = (p == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Runs on one channel build up its recursion; the rest hop between channels.
        if ($urandom_range(3) != 0) begin
          ch = CHAN_W'($urandom_range(MAX_CHANNELS_DEF - 1));
        end
        push_sample(ch, pick_sample());
      end
      drain();
      steady = 1'b0;
    end

    $display("run covered %0d samples under %0d coefficient sets on all channels,", sent,
             coef_sets);
    $display("including rounding midpoints, saturation and stalls on both sides");
    if (err_cnt == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

endmodule
